[src/rme_pkg.sv]
// Shared constants and types for the modular exponentiation core.
// Used by rme_modmul and rsa_modular_exponentiation_core; no dependencies.
`timescale 1ns / 1ps

package rme_pkg;

  // Operand width: value, modulus and exponents are taken as their low WIDTH bits.
  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);

  // Fixed port widths.
  localparam int DATA_W = 32;
  localparam int CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODULUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PUB_EXP = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRIV_EXP = 2'd2;

  // Request into the shared modular multiplier.
  typedef struct packed {
    logic             start;
    logic [WIDTH-1:0] multiplier;  // scanned MSB first, may be unreduced
    logic [WIDTH-1:0] addend;      // must not exceed modulus
    logic [WIDTH-1:0] modulus;
  } mm_req_t;

  // Response from the shared modular multiplier.
  typedef struct packed {
    logic             done;
    logic [WIDTH-1:0] product;
  } mm_rsp_t;

endpackage

[src/rsa_modular_exponentiation_core.sv]
// Modular exponentiation core: result = value ** exponent mod modulus, with the
// exponent chosen by mode (0 public, 1 private). An item runs one base
// reduction and, per exponent bit, an optional multiply and a square, each a
// pass through the single shift-add modular multiplier. A zero modulus returns
// 0 without a multiplier pass. in_stall stays high from acceptance until the
// result beat has been taken. Configuration writes are always ready and must
// only be issued while the core is idle.
// Depends on rme_pkg and rme_modmul.
`timescale 1ns / 1ps

module rsa_modular_exponentiation_core (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_mode,
  input  logic [rme_pkg::DATA_W-1:0]        in_value,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rme_pkg::DATA_W-1:0]        out_result,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rme_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rme_pkg::DATA_W-1:0]        cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RED,
    S_MUL,
    S_SQR,
    S_OUT
  } state_t;

  state_t                     state_r;
  logic                       go_r;
  logic [rme_pkg::WIDTH-1:0]  mod_cfg_r;
  logic [rme_pkg::WIDTH-1:0]  pub_r;
  logic [rme_pkg::WIDTH-1:0]  priv_r;
  logic [rme_pkg::WIDTH-1:0]  mod_r;
  logic [rme_pkg::WIDTH-1:0]  exp_r;
  logic [rme_pkg::WIDTH-1:0]  base_r;
  logic [rme_pkg::WIDTH-1:0]  acc_r;
  logic [rme_pkg::CNT_W-1:0]  bit_r;
  logic                       out_valid_r;
  logic [rme_pkg::DATA_W-1:0] out_result_r;

  rme_pkg::mm_req_t mm_req;
  rme_pkg::mm_rsp_t mm_rsp;

  assign cfg_ready  = 1'b1;
  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mod_cfg_r <= rme_pkg::WIDTH'(1);
      pub_r     <= rme_pkg::WIDTH'(1);
      priv_r    <= rme_pkg::WIDTH'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        rme_pkg::REG_MODULUS:  mod_cfg_r <= rme_pkg::WIDTH'(cfg_data);
        rme_pkg::REG_PUB_EXP:  pub_r     <= rme_pkg::WIDTH'(cfg_data);
        rme_pkg::REG_PRIV_EXP: priv_r    <= rme_pkg::WIDTH'(cfg_data);
        default: ;
      endcase
    end
  end

  // Operand routing for the shared multiplier.
  always_comb begin
    mm_req.start   = go_r;
    mm_req.modulus = mod_r;
    case (state_r)
      S_RED: begin
        // base mod m as base * 1 mod m
        mm_req.multiplier = base_r;
        mm_req.addend     = rme_pkg::WIDTH'(1);
      end
      S_MUL: begin
        mm_req.multiplier = acc_r;
        mm_req.addend     = base_r;
      end
      default: begin
        mm_req.multiplier = base_r;
        mm_req.addend     = base_r;
      end
    endcase
  end

  rme_modmul u_modmul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mm_req),
    .rsp   (mm_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      bit_r       <= '0;
    end else begin
      go_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            mod_r  <= mod_cfg_r;
            exp_r  <= in_mode ? priv_r : pub_r;
            base_r <= rme_pkg::WIDTH'(in_value);
            acc_r  <= rme_pkg::WIDTH'(1);
            bit_r  <= '0;
            if (mod_cfg_r == '0) begin
              out_result_r <= '0;
              out_valid_r  <= 1'b1;
              state_r      <= S_OUT;
            end else begin
              go_r    <= 1'b1;
              state_r <= S_RED;
            end
          end
        end
        S_RED: begin
          if (mm_rsp.done) begin
            base_r  <= mm_rsp.product;
            go_r    <= 1'b1;
            state_r <= exp_r[0] ? S_MUL : S_SQR;
          end
        end
        S_MUL: begin
          if (mm_rsp.done) begin
            acc_r   <= mm_rsp.product;
            go_r    <= 1'b1;
            state_r <= S_SQR;
          end
        end
        S_SQR: begin
          if (mm_rsp.done) begin
            base_r <= mm_rsp.product;
            exp_r  <= exp_r >> 1;
            bit_r  <= bit_r + 1'b1;
            if (bit_r == rme_pkg::CNT_W'(rme_pkg::WIDTH - 1)) begin
              out_result_r <= rme_pkg::DATA_W'(acc_r);
              out_valid_r  <= 1'b1;
              state_r      <= S_OUT;
            end else begin
              go_r    <= 1'b1;
              state_r <= exp_r[1] ? S_MUL : S_SQR;
            end
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid_r <= 1'b0;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[src/rme_modmul.sv]
// Shift-add modular multiplier: product = multiplier * addend mod modulus.
// One multiplier bit per cycle, WIDTH bits per product. Depends on rme_pkg.
`timescale 1ns / 1ps

module rme_modmul (
  input  logic            clk,
  input  logic            rst_n,
  input  rme_pkg::mm_req_t req,
  output rme_pkg::mm_rsp_t rsp
);

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t                     state_r;
  logic [rme_pkg::WIDTH-1:0]  mult_r;
  logic [rme_pkg::WIDTH-1:0]  addend_r;
  logic [rme_pkg::WIDTH-1:0]  mod_r;
  logic [rme_pkg::WIDTH-1:0]  rem_r;
  logic [rme_pkg::WIDTH-1:0]  rem_nxt;
  logic [rme_pkg::CNT_W-1:0]  cnt_r;
  logic                       done_r;

  logic [rme_pkg::WIDTH+1:0]  sum;
  logic [rme_pkg::WIDTH+1:0]  mod1;
  logic [rme_pkg::WIDTH+1:0]  mod2;

  // rem < mod and addend <= mod, so 2*rem + addend < 3*mod: one of two subtracts.
  always_comb begin
    mod1 = {2'b00, mod_r};
    mod2 = {1'b0, mod_r, 1'b0};
    sum  = {1'b0, rem_r, 1'b0} +
           (mult_r[rme_pkg::WIDTH-1] ? {2'b00, addend_r} : '0);
    if (sum >= mod2) begin
      rem_nxt = rme_pkg::WIDTH'(sum - mod2);
    end else if (sum >= mod1) begin
      rem_nxt = rme_pkg::WIDTH'(sum - mod1);
    end else begin
      rem_nxt = rme_pkg::WIDTH'(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      done_r  <= 1'b0;
      cnt_r   <= '0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (req.start) begin
            mult_r   <= req.multiplier;
            addend_r <= req.addend;
            mod_r    <= req.modulus;
            rem_r    <= '0;
            cnt_r    <= rme_pkg::CNT_W'(rme_pkg::WIDTH - 1);
            state_r  <= S_RUN;
          end
        end
        S_RUN: begin
          rem_r  <= rem_nxt;
          mult_r <= mult_r << 1;
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            done_r  <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign rsp.done    = done_r;
  assign rsp.product = rem_r;

endmodule

[sim/tb.sv]
// Testbench for rsa_modular_exponentiation_core: directed and random modular powers
// across several key settings, checked beat by beat against an in-bench predictor.
// Depends on rme_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb;

  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;
  localparam logic [rme_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 250;

  // Expected powers, oldest first, plus a private copy of the key registers.
  class modexp_scoreboard;
    bit [rme_pkg::DATA_W-1:0] modulus;
    bit [rme_pkg::DATA_W-1:0] pub_exp;
    bit [rme_pkg::DATA_W-1:0] priv_exp;
    bit [rme_pkg::DATA_W-1:0] expected_powers[$];
    int errors;

    function new();
      modulus = 1;
      pub_exp = 1;
      priv_exp = 1;
      errors = 0;
    endfunction

    function void set_register(bit [rme_pkg::CFG_IDX_W-1:0] idx,
                               bit [rme_pkg::DATA_W-1:0] data);
      case (idx)
        rme_pkg::REG_MODULUS:  modulus = data;
        rme_pkg::REG_PUB_EXP:  pub_exp = data;
        rme_pkg::REG_PRIV_EXP: priv_exp = data;
        default: ;
      endcase
    endfunction

    function bit [rme_pkg::DATA_W-1:0] narrow(bit [rme_pkg::DATA_W-1:0] x);
      bit [63:0] mask;
      mask = (64'd1 << rme_pkg::WIDTH) - 64'd1;
      return x & mask[rme_pkg::DATA_W-1:0];
    endfunction

    // right-to-left square and multiply, exact 64-bit products
    function bit [rme_pkg::DATA_W-1:0] power_mod(bit [rme_pkg::DATA_W-1:0] base,
                                                 bit [rme_pkg::DATA_W-1:0] ex,
                                                 bit [rme_pkg::DATA_W-1:0] m);
      bit [63:0] acc;
      bit [63:0] sq;
      bit [63:0] m64;
      if (m == 0) return '0;
      m64 = {32'd0, m};
      acc = 64'd1;
      sq = {32'd0, base} % m64;
      for (int i = 0; i < rme_pkg::WIDTH; i++) begin
        if (ex[i]) acc = (acc * sq) % m64;
        sq = (sq * sq) % m64;
      end
      return acc[rme_pkg::DATA_W-1:0];
    endfunction

    function void note_input(bit mode, bit [rme_pkg::DATA_W-1:0] value);
      bit [rme_pkg::DATA_W-1:0] ex;
      ex = (mode == MODE_DECRYPT) ? priv_exp : pub_exp;
      expected_powers.push_back(power_mod(narrow(value), narrow(ex), narrow(modulus)));
    endfunction

    function void check_result(bit [rme_pkg::DATA_W-1:0] actual);
      bit [rme_pkg::DATA_W-1:0] want;
      if (expected_powers.size() == 0) begin
        $display("%0t unexpected result beat: expected none actual %h", $time, actual);
        errors++;
      end else begin
        want = expected_powers.pop_front();
        if (want !== actual) begin
          $display("%0t result mismatch: expected %h actual %h", $time, want, actual);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_powers.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_mode = MODE_ENCRYPT;
  logic [rme_pkg::DATA_W-1:0]    in_value = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [rme_pkg::DATA_W-1:0]    out_result;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [rme_pkg::CFG_IDX_W-1:0] cfg_index = rme_pkg::REG_MODULUS;
  logic [rme_pkg::DATA_W-1:0]    cfg_data = '0;

  bit calm = 1'b0;
  modexp_scoreboard sb;

  rsa_modular_exponentiation_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_mode    (in_mode),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // monitor: register writes, accepted operands and result beats
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_input(in_mode, in_value);
      if (out_valid && !out_stall) sb.check_result(out_result);
    end
  end

  // result-side backpressure: short bursts, with occasional long open stretches
  initial begin
    do @(posedge clk); while (!rst_n);
    while (!calm) begin
      if ($urandom_range(0, 7) == 0) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(200, 3000)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  task automatic offer_operand(input logic mode, input logic [rme_pkg::DATA_W-1:0] value);
    int gap;
    gap = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= mode;
    in_value <= value;
    do @(posedge clk); while (in_stall);
  endtask

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_key_reg(input logic [rme_pkg::CFG_IDX_W-1:0] idx,
                               input logic [rme_pkg::DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic drain(input int tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  task automatic load_keys(input logic [rme_pkg::DATA_W-1:0] m,
                           input logic [rme_pkg::DATA_W-1:0] e,
                           input logic [rme_pkg::DATA_W-1:0] d);
    drain(4);
    write_key_reg(rme_pkg::REG_MODULUS, m);
    write_key_reg(rme_pkg::REG_PUB_EXP, e);
    write_key_reg(rme_pkg::REG_PRIV_EXP, d);
    // out-of-range index must not disturb the keys
    write_key_reg(REG_UNUSED, $urandom);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [rme_pkg::DATA_W-1:0] pick_modulus();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom | 32'h8000_0000;
      4, 5:       return $urandom;
      6:          return $urandom_range(2, 65535);
      7:          return 32'hFFFF_FFFF;
      8:          return 32'd1;
      default:    return $urandom_range(0, 3);
    endcase
  endfunction

  function automatic logic [rme_pkg::DATA_W-1:0] pick_exponent();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return $urandom;
      5:             return '0;
      6:             return 32'hFFFF_FFFF;
      7:             return $urandom_range(1, 65537);
      8:             return 32'd1 << $urandom_range(0, 31);
      default:       return 32'd1;
    endcase
  endfunction

  function automatic logic [rme_pkg::DATA_W-1:0] pick_value(
      input logic [rme_pkg::DATA_W-1:0] m);
    case ($urandom_range(0, 7))
      0, 1, 2: return $urandom;
      3:       return (m == 0) ? '0 : $urandom % m;
      4:       return m - 32'd1;
      5:       return '0;
      6:       return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 255);
    endcase
  endfunction

  initial begin
    logic [rme_pkg::DATA_W-1:0] m;
    int done_items;
    int batch;

    sb = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset keys: modulus one, exponents one
    offer_operand(MODE_ENCRYPT, 32'd7);
    offer_operand(MODE_DECRYPT, 32'hFFFF_FFFF);

    load_keys(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    offer_operand(MODE_ENCRYPT, 32'd0);
    offer_operand(MODE_ENCRYPT, 32'd1);
    offer_operand(MODE_ENCRYPT, 32'hFFFF_FFFF);
    offer_operand(MODE_ENCRYPT, 32'hFFFF_FFFE);
    offer_operand(MODE_DECRYPT, 32'h8000_0000);
    offer_operand(MODE_DECRYPT, 32'hFFFF_FFFF);
    offer_operand(MODE_ENCRYPT, 32'h1234_5678);

    // zero modulus gives zero, even with a zero exponent
    load_keys(32'd0, $urandom, 32'd0);
    offer_operand(MODE_ENCRYPT, $urandom);
    offer_operand(MODE_DECRYPT, 32'd0);

    // modulus one: zero exponent still yields one
    load_keys(32'd1, 32'd0, 32'd5);
    offer_operand(MODE_ENCRYPT, 32'd9);
    offer_operand(MODE_DECRYPT, 32'd9);

    // textbook key pair, including a value above the modulus
    load_keys(32'd3233, 32'd17, 32'd2753);
    offer_operand(MODE_ENCRYPT, 32'd65);
    offer_operand(MODE_DECRYPT, 32'd2790);
    offer_operand(MODE_ENCRYPT, 32'd3232);
    offer_operand(MODE_DECRYPT, 32'hFFFF_FFFF);

    load_keys(32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
    offer_operand(MODE_ENCRYPT, 32'd3);
    offer_operand(MODE_DECRYPT, 32'd3);
    offer_operand(MODE_ENCRYPT, 32'hFFFF_FFFF);

    done_items = 0;
    while (done_items < RANDOM_ITEMS) begin
      m = pick_modulus();
      load_keys(m, pick_exponent(), pick_exponent());
      batch = $urandom_range(8, 30);
      if (batch > RANDOM_ITEMS - done_items) batch = RANDOM_ITEMS - done_items;
      repeat (batch) begin
        calm = (done_items >= RANDOM_ITEMS - 30);
        offer_operand($urandom_range(0, 1) ? MODE_DECRYPT : MODE_ENCRYPT, pick_value(m));
        done_items++;
      end
    end

    // room for a stray beat from a full-length pass
    drain(2500);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
